FILE: rtl/core/bmcr_pkg.sv
// bmcr_pkg: shared constants and controller/datapath interface types
// for the byte memory with change range unit. No dependencies.
package bmcr_pkg;

   localparam int MEM_BYTES_DEFAULT = 65536;

   // operation codes
   localparam logic [2:0] OP_READ    = 3'd0;
   localparam logic [2:0] OP_WRITE   = 3'd1;
   localparam logic [2:0] OP_DEPOSIT = 3'd2;
   localparam logic [2:0] OP_QUERY   = 3'd3;
   localparam logic [2:0] OP_CLEAR   = 3'd4;

   localparam logic [3:0] MAX_BYTES  = 4'd8;

   // controller -> datapath
   typedef struct packed {
      logic latch;     // capture request fields
      logic check;     // validate, update change record, set up byte walk
      logic rd_step;   // issue one byte read
      logic wr_step;   // write one byte
      logic clr_step;  // clear one byte after reset
      logic load_rsp;  // move result into output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_rd;   // checked item is a good read
      logic need_wr;   // checked item is a good write or deposit
      logic last_byte; // current byte is the last of the access
      logic clr_last;  // clearing pass at final address
   } sts_type;

endpackage

FILE: rtl/core/byte_memory_with_change_range_unit.sv
// byte_memory_with_change_range_unit: top level, joins controller and datapath.
// Depends on bmcr_pkg, bmcr_ctrl and bmcr_datapath.
//
// Byte-addressed store of MEM_BYTES bytes behind a valid/stall request and
// response channel; every accepted request gives exactly one response.
// Reads return 1, 2, 4 or 8 bytes big-endian (lowest address = most
// significant byte); writes store 1 to 8 bytes the same way and update a
// single changed-address range (a write starting just past the range end
// extends it, any other good write restarts it). Deposit stores one byte
// without touching the range; query reports whether an address lies in the
// range; clear empties it. Bad sizes, unknown operations and accesses that
// run past the store end give status 1 and change nothing. After reset the
// store is zeroed by a clearing pass over all MEM_BYTES bytes (65536 by
// default), one byte per cycle, with req_stall held high. Timing: the
// store is a single-port byte-wide memory, so an access walks its bytes
// one per cycle. Each request passes latch and check steps, then a byte
// walk for good reads, writes and deposits, then the result load; a read
// adds a drain step for the registered read data. The response sits in an
// output register, so the next request is taken while an earlier response
// is still stalled; only the final load waits for that register to free up.
module byte_memory_with_change_range_unit #(
   parameter int MEM_BYTES = bmcr_pkg::MEM_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_operation,
   input  logic [3:0]  req_access_size,
   input  logic [31:0] req_address,
   input  logic [63:0] req_write_data,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_read_data,
   output logic        rsp_status,
   output logic        rsp_in_changed_range
);
   import bmcr_pkg::*;

   cmd_type cmd;   // sequencing commands
   sts_type sts;   // check results and walk status

   // controller: clearing pass, request acceptance, byte walk, result hand-off
   bmcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: store, change record and response payload
   bmcr_datapath #(
      .MEM_BYTES (MEM_BYTES)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_operation        (req_operation),
      .req_access_size      (req_access_size),
      .req_address          (req_address),
      .req_write_data       (req_write_data),
      .rsp_read_data        (rsp_read_data),
      .rsp_status           (rsp_status),
      .rsp_in_changed_range (rsp_in_changed_range)
   );

endmodule

FILE: rtl/core/bmcr_ctrl.sv
// bmcr_ctrl: sequencing state machine for the byte memory unit.
// Depends on bmcr_pkg (cmd_type, sts_type).
module bmcr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  bmcr_pkg::sts_type sts,
   output bmcr_pkg::cmd_type cmd
);
   import bmcr_pkg::*;

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_CHECK = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_DRAIN = 3'd4;
   localparam logic [2:0] S_WRITE = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            if (sts.need_rd)      state_in = S_READ;
            else if (sts.need_wr) state_in = S_WRITE;
            else                  state_in = S_DONE;
         end
         S_READ: begin
            cmd.rd_step = 1'b1;
            if (sts.last_byte) state_in = S_DRAIN;
         end
         S_DRAIN: state_in = S_DONE; // last byte lands in the shifter
         S_WRITE: begin
            cmd.wr_step = 1'b1;
            if (sts.last_byte) state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/core/bmcr_datapath.sv
// bmcr_datapath: byte store, request registers, byte walker, change record
// and result register. Depends on bmcr_pkg.
module bmcr_datapath #(
   parameter int MEM_BYTES = bmcr_pkg::MEM_BYTES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  bmcr_pkg::cmd_type cmd,
   output bmcr_pkg::sts_type sts,
   input  logic [2:0]        req_operation,
   input  logic [3:0]        req_access_size,
   input  logic [31:0]       req_address,
   input  logic [63:0]       req_write_data,
   output logic [63:0]       rsp_read_data,
   output logic              rsp_status,
   output logic              rsp_in_changed_range
);
   import bmcr_pkg::*;

   localparam int AW = $clog2(MEM_BYTES);

   logic [7:0]    mem [MEM_BYTES];
   logic [7:0]    mem_q_ff;

   logic [2:0]    op_ff;
   logic [3:0]    size_ff;
   logic [31:0]   addr_ff;
   logic [63:0]   data_ff;

   logic [3:0]    eff_size;
   logic          size_ok_rd, size_ok_wr, fits;
   logic          good_rd, good_wr, good_dep, bad;
   logic          hit;
   logic          extend;
   logic [AW:0]   last_next;
   logic [2:0]    pre_shift;

   logic [63:0]   wdata_ff;
   logic [3:0]    len_ff;
   logic [2:0]    cnt_ff;
   logic [AW-1:0] cur_addr_ff;
   logic          rd_pend_ff;
   logic [63:0]   rd_ff;
   logic          stat_ff, hit_ff;

   logic          chg_valid_ff;
   logic [AW-1:0] chg_first_ff, chg_last_ff;

   logic [63:0]   rsp_data_ff;
   logic          rsp_stat_ff, rsp_hit_ff;

   logic          mem_we;
   logic [7:0]    mem_wd;

   // ---- checks on the latched request ----
   assign eff_size   = (op_ff == OP_DEPOSIT) ? 4'd1 : size_ff;
   assign size_ok_rd = (size_ff inside {4'd1, 4'd2, 4'd4, 4'd8});
   assign size_ok_wr = (size_ff != 4'd0) && (size_ff <= MAX_BYTES);
   assign fits       = ({1'b0, addr_ff} + {29'd0, eff_size}) <= 33'(MEM_BYTES);
   assign good_rd    = (op_ff == OP_READ)    && size_ok_rd && fits;
   assign good_wr    = (op_ff == OP_WRITE)   && size_ok_wr && fits;
   assign good_dep   = (op_ff == OP_DEPOSIT) && fits;
   assign bad        = !(good_rd || good_wr || good_dep ||
                         op_ff == OP_QUERY || op_ff == OP_CLEAR);
   assign hit        = (op_ff == OP_QUERY) && chg_valid_ff &&
                       (addr_ff >= 32'(chg_first_ff)) && (addr_ff <= 32'(chg_last_ff));
   assign last_next  = {1'b0, chg_last_ff} + (AW+1)'(1);
   assign extend     = chg_valid_ff && (addr_ff == 32'(last_next));
   assign pre_shift  = 3'(MAX_BYTES - eff_size);

   assign sts.need_rd   = good_rd;
   assign sts.need_wr   = good_wr || good_dep;
   assign sts.last_byte = ({1'b0, cnt_ff} == (len_ff - 4'd1));
   assign sts.clr_last  = (32'(cur_addr_ff) == 32'(MEM_BYTES - 1));

   // ---- byte store: one access per cycle ----
   assign mem_we = cmd.wr_step | cmd.clr_step;
   assign mem_wd = cmd.clr_step ? 8'd0 : wdata_ff[63:56];

   always_ff @(posedge clock) begin
      if (mem_we) mem[cur_addr_ff] <= mem_wd;
      mem_q_ff <= mem[cur_addr_ff];
   end

   // ---- control-bearing registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_addr_ff  <= '0;
         rd_pend_ff   <= 1'b0;
         chg_valid_ff <= 1'b0;
         chg_first_ff <= '0;
         chg_last_ff  <= '0;
      end else begin
         rd_pend_ff <= cmd.rd_step;
         if (cmd.check) begin
            cur_addr_ff <= addr_ff[AW-1:0];
            if (good_wr) begin
               if (!extend) begin
                  chg_valid_ff <= 1'b1;
                  chg_first_ff <= addr_ff[AW-1:0];
               end
               chg_last_ff <= addr_ff[AW-1:0] + AW'(size_ff) - AW'(1);
            end
            if (op_ff == OP_CLEAR) chg_valid_ff <= 1'b0;
         end else if (cmd.rd_step || cmd.wr_step || cmd.clr_step) begin
            cur_addr_ff <= cur_addr_ff + AW'(1);
         end
      end
   end

   // ---- payload registers ----
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff   <= req_operation;
         size_ff <= req_access_size;
         addr_ff <= req_address;
         data_ff <= req_write_data;
         rd_ff   <= '0;
      end else if (rd_pend_ff) begin
         rd_ff <= {rd_ff[55:0], mem_q_ff};
      end
      if (cmd.check) begin
         // lowest-address byte moves to the top, sent out first
         wdata_ff <= data_ff << {pre_shift, 3'b000};
         len_ff   <= eff_size;
         cnt_ff   <= '0;
         stat_ff  <= bad;
         hit_ff   <= hit;
      end else if (cmd.rd_step || cmd.wr_step) begin
         wdata_ff <= {wdata_ff[55:0], 8'd0};
         cnt_ff   <= cnt_ff + 3'd1;
      end
      if (cmd.load_rsp) begin
         rsp_data_ff <= rd_ff;
         rsp_stat_ff <= stat_ff;
         rsp_hit_ff  <= hit_ff;
      end
   end

   assign rsp_read_data        = rsp_data_ff;
   assign rsp_status           = rsp_stat_ff;
   assign rsp_in_changed_range = rsp_hit_ff;

endmodule
